FILE: hdl/pitcoe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitcoe_pkg
// Shared types, constants and helpers for the timer channel output evaluator.
// ----------------------------------------------------------------------------
package pitcoe_pkg;

	localparam int unsigned COUNT_BITS = 17;
	localparam int unsigned MODE_BITS  = 3;
	localparam logic [COUNT_BITS-1:0] FULL_COUNT = 17'h10000;
	localparam logic [MODE_BITS-1:0]  RESET_MODE = 3'd3;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		MODE_ONE_SHOT,
		MODE_RATE,
		MODE_SQUARE,
		MODE_STROBE
	} mode_class_t;

	typedef enum logic [0:0] {
		REG_COUNTER_MODE = 1'b0,
		REG_RELOAD_COUNT = 1'b1
	} reg_index_t;

	typedef struct packed {
		mode_class_t mode;
		count_t      count;
	} cfg_t;

	// Top mode bit is ignored for six and seven.
	function automatic mode_class_t mode_class(input logic [MODE_BITS-1:0] mode);
		mode_class_t cls;
		case (mode) inside
			3'd0, 3'd1: cls = MODE_ONE_SHOT;
			3'd2, 3'd6: cls = MODE_RATE;
			3'd3, 3'd7: cls = MODE_SQUARE;
			default:    cls = MODE_STROBE;
		endcase
		return cls;
	endfunction

	// Zero and anything above a full count load as a full count.
	function automatic count_t effective_count(input count_t raw);
		count_t c;
		if (raw == '0 || raw > FULL_COUNT) begin
			c = FULL_COUNT;
		end else begin
			c = raw;
		end
		return c;
	endfunction

endpackage

FILE: hdl/pitcoe_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitcoe_div_cell
// One restoring step of the tick-count remainder: shifts in one tick bit,
// subtracts the reload count when it fits, and hands the beat on.
// ----------------------------------------------------------------------------
module pitcoe_div_cell #(
	parameter int unsigned TICK_BITS = 48,
	parameter int unsigned BIT_POS   = 47
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  pitcoe_pkg::count_t     divisor,
	input  logic                   valid_i,
	input  logic [TICK_BITS-1:0]   ticks_i,
	input  pitcoe_pkg::count_t     rem_i,
	output logic                   valid_o,
	output logic [TICK_BITS-1:0]   ticks_o,
	output pitcoe_pkg::count_t     rem_o
);
	import pitcoe_pkg::*;

	logic [COUNT_BITS:0] trial;
	logic [COUNT_BITS:0] diff;
	count_t              rem_next;
	logic                valid_q;
	logic [TICK_BITS-1:0] ticks_q;
	count_t              rem_q;

	assign trial    = {rem_i, ticks_i[BIT_POS]};
	assign diff     = trial - {1'b0, divisor};
	// top bit of the difference is the borrow: keep the trial when it is set
	assign rem_next = diff[COUNT_BITS] ? trial[COUNT_BITS-1:0]
	                                   : diff[COUNT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ticks_q <= ticks_i;
			rem_q   <= rem_next;
		end
	end

	assign valid_o = valid_q;
	assign ticks_o = ticks_q;
	assign rem_o   = rem_q;

endmodule

FILE: hdl/pitcoe_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitcoe_eval
// Turns ticks and their remainder into the output level and the tick of the
// next output change: a decode stage, then the final add into the output
// register.
// ----------------------------------------------------------------------------
module pitcoe_eval #(
	parameter int unsigned TICK_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  pitcoe_pkg::cfg_t     cfg,
	input  logic                 valid_i,
	input  logic [TICK_BITS-1:0] ticks_i,
	input  pitcoe_pkg::count_t   rem_i,
	output logic                 valid_o,
	output logic                 level_o,
	output logic                 has_o,
	output logic [TICK_BITS:0]   next_o
);
	import pitcoe_pkg::*;

	logic [COUNT_BITS:0]  count_x;
	logic [COUNT_BITS:0]  count_p1;
	count_t               half;
	logic [TICK_BITS-1:0] count_w;
	logic [TICK_BITS-1:0] base_rem;
	logic                 d_lt;
	logic                 d_eq;

	logic                 level_a;
	logic                 has_a;
	logic [TICK_BITS-1:0] base_a;
	logic [COUNT_BITS:0]  add_a;

	logic                 valid_s1;
	logic                 level_s1;
	logic                 has_s1;
	logic [TICK_BITS-1:0] base_s1;
	logic [COUNT_BITS:0]  add_s1;

	logic                 valid_s2;
	logic                 level_s2;
	logic                 has_s2;
	logic [TICK_BITS:0]   next_s2;

	assign count_x  = {1'b0, cfg.count};
	assign count_p1 = count_x + 1'b1;
	assign half     = count_p1[COUNT_BITS:1];
	assign count_w  = TICK_BITS'(cfg.count);
	assign base_rem = ticks_i - TICK_BITS'(rem_i);
	assign d_lt     = ticks_i < count_w;
	assign d_eq     = ticks_i == count_w;

	always_comb begin
		level_a = 1'b0;
		has_a   = 1'b0;
		base_a  = '0;
		add_a   = '0;
		case (cfg.mode)
			MODE_RATE: begin
				level_a = (rem_i == '0) && (ticks_i != '0);
				has_a   = 1'b1;
				base_a  = base_rem;
				add_a   = level_a ? count_x : count_p1;
			end
			MODE_SQUARE: begin
				level_a = rem_i < half;
				has_a   = 1'b1;
				base_a  = base_rem;
				add_a   = level_a ? {1'b0, half} : count_x;
			end
			MODE_STROBE: begin
				level_a = d_eq;
				has_a   = d_lt || d_eq;
				if (d_lt) begin
					add_a = count_x;
				end else if (d_eq) begin
					add_a = count_p1;
				end
			end
			default: begin
				level_a = !d_lt;
				has_a   = d_lt;
				if (d_lt) begin
					add_a = count_x;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_s1 <= level_a;
			has_s1   <= has_a;
			base_s1  <= base_a;
			add_s1   <= add_a;
			level_s2 <= level_s1;
			has_s2   <= has_s1;
			next_s2  <= {1'b0, base_s1} + (TICK_BITS+1)'(add_s1);
		end
	end

	assign valid_o = valid_s2;
	assign level_o = level_s2;
	assign has_o   = has_s2;
	assign next_o  = next_s2;

endmodule

FILE: hdl/pit_channel_output_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_channel_output_evaluator_unit
// Output level and next transition tick of one interval timer channel.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat carries the ticks elapsed since the count was
//   loaded. Master stream: one beat per input beat with the output level,
//   a flag for a pending transition and the tick of that transition.
//   Config channel: index 0 writes the counter mode, index 1 the reload
//   count; always ready, write only while no beat is in flight.
//   A row of TICK_BITS remainder cells, one bit of the tick count per
//   cell, feeds a decode stage and an add stage that is also the output
//   register. One beat enters every cycle unless the output is stalled.
//   When the receiver stalls with a result waiting, the whole row holds and
//   s_axis_tready drops in the same cycle; nothing is lost.
//   Reset empties the row and loads mode 3 with a full count of 65536.
// ----------------------------------------------------------------------------
module pit_channel_output_evaluator_unit #(
	parameter int unsigned TICK_BITS = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// elapsed_ticks
	input  logic [((TICK_BITS+7)/8)*8-1:0]        s_axis_tdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// output_level, has_transition, next_transition_tick
	output logic [((TICK_BITS+3+7)/8)*8-1:0]      m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [0:0]                            cfg_index,
	input  pitcoe_pkg::count_t                    cfg_data
);
	import pitcoe_pkg::*;

	localparam int unsigned OUT_W = ((TICK_BITS + 3 + 7) / 8) * 8;

	mode_class_t          mode_q;
	count_t               count_q;
	cfg_t                 cfg;
	logic                 en;

	logic                 valid_c [0:TICK_BITS];
	logic [TICK_BITS-1:0] ticks_c [0:TICK_BITS];
	count_t               rem_c   [0:TICK_BITS];

	logic                 level;
	logic                 has;
	logic [TICK_BITS:0]   next_tick;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= mode_class(RESET_MODE);
			count_q <= FULL_COUNT;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_COUNTER_MODE: mode_q  <= mode_class(cfg_data[MODE_BITS-1:0]);
				REG_RELOAD_COUNT: count_q <= effective_count(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg.mode  = mode_q;
	assign cfg.count = count_q;

	// advance the whole row unless a finished result is stuck at the output
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	assign valid_c[0] = s_axis_tvalid;
	assign ticks_c[0] = s_axis_tdata[TICK_BITS-1:0];
	assign rem_c[0]   = '0;

	for (genvar k = 0; k < TICK_BITS; k++) begin : g_cell
		pitcoe_div_cell #(
			.TICK_BITS (TICK_BITS),
			.BIT_POS   (TICK_BITS - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.divisor (count_q),
			.valid_i (valid_c[k]),
			.ticks_i (ticks_c[k]),
			.rem_i   (rem_c[k]),
			.valid_o (valid_c[k+1]),
			.ticks_o (ticks_c[k+1]),
			.rem_o   (rem_c[k+1])
		);
	end

	pitcoe_eval #(
		.TICK_BITS (TICK_BITS)
	) u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg),
		.valid_i (valid_c[TICK_BITS]),
		.ticks_i (ticks_c[TICK_BITS]),
		.rem_i   (rem_c[TICK_BITS]),
		.valid_o (m_axis_tvalid),
		.level_o (level),
		.has_o   (has),
		.next_o  (next_tick)
	);

	assign m_axis_tdata = OUT_W'({next_tick, has, level});

`ifndef SYNTHESIS
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	a_no_transition_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !has |-> next_tick == '0)
		else $error("next tick nonzero without a transition");

	a_transition_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && has |-> next_tick != '0)
		else $error("pending transition at tick zero");
`endif

endmodule

FILE: bench/pit_channel_output_evaluator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_channel_output_evaluator_unit_tb
// Self-checking bench for the timer channel output evaluator. Tick queries
// stream in under random source gaps and sink back-pressure. A scoreboard
// predicts output level, pending-transition flag and next transition tick
// for each accepted query under the current mode and reload count, and
// compares every result beat in order. Registers change only between
// phases, once the pipeline has drained.
// ----------------------------------------------------------------------------
module pit_channel_output_evaluator_unit_tb;

	import pitcoe_pkg::*;

	localparam int unsigned TICK_BITS   = 48;
	localparam int unsigned IN_W        = ((TICK_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_W       = ((TICK_BITS + 3 + 7) / 8) * 8;
	localparam int unsigned LATENCY     = TICK_BITS + 2;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned RAND_PHASES = 20;
	localparam int unsigned PRESSURE_PH = 4;

	typedef struct packed {
		logic                 level;
		logic                 has_next;
		logic [TICK_BITS:0]   next_tick;
	} channel_out_t;

	class pit_output_scoreboard;
		logic [MODE_BITS-1:0] mode;
		count_t               count;
		channel_out_t         expected_q[$];
		int                   mismatches;
		int                   checked;

		function new();
			mode       = RESET_MODE;
			count      = FULL_COUNT;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void write_reg(reg_index_t idx, count_t data);
			if (idx == REG_COUNTER_MODE) begin
				mode = data[MODE_BITS-1:0];
			end else begin
				count = data;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function channel_out_t predict(logic [TICK_BITS-1:0] ticks);
			logic [63:0]          d, c, rem, base, half, nxt;
			logic [MODE_BITS-1:0] m;
			mode_class_t          cls;
			channel_out_t         r;
			d = 64'(ticks);
			c = 64'(count);
			if (c == 0 || c > 64'(FULL_COUNT)) begin
				c = 64'(FULL_COUNT);
			end
			// six and seven fold onto two and three
			m = mode;
			if (m >= 3'd6) begin
				m = m - 3'd4;
			end
			case (m)
				3'd0, 3'd1: cls = MODE_ONE_SHOT;
				3'd2:       cls = MODE_RATE;
				3'd3:       cls = MODE_SQUARE;
				default:    cls = MODE_STROBE;
			endcase
			rem  = d % c;
			base = d - rem;
			half = (c + 1) >> 1;
			nxt  = 0;
			r    = '0;
			case (cls)
				MODE_RATE: begin
					r.has_next = 1'b1;
					if (rem == 0 && d != 0) begin
						r.level = 1'b1;
						nxt     = base + c;
					end else begin
						nxt = base + c + 1;
					end
				end
				MODE_SQUARE: begin
					r.has_next = 1'b1;
					if (rem < half) begin
						r.level = 1'b1;
						nxt     = base + half;
					end else begin
						nxt = base + c;
					end
				end
				MODE_STROBE: begin
					r.level = (d == c);
					if (d < c) begin
						r.has_next = 1'b1;
						nxt        = c;
					end else if (d == c) begin
						r.has_next = 1'b1;
						nxt        = c + 1;
					end
				end
				default: begin
					r.level = (d >= c);
					if (d < c) begin
						r.has_next = 1'b1;
						nxt        = c;
					end
				end
			endcase
			r.next_tick = nxt[TICK_BITS:0];
			return r;
		endfunction

		function void note_query(logic [TICK_BITS-1:0] ticks);
			expected_q.push_back(predict(ticks));
		endfunction

		function void check_result(logic [OUT_W-1:0] beat);
			channel_out_t exp_out;
			logic               lvl, has;
			logic [TICK_BITS:0] nxt;
			lvl = beat[0];
			has = beat[1];
			nxt = beat[TICK_BITS+2:2];
			if (expected_q.size() == 0) begin
				$error("result beat with no query outstanding: %h", beat);
				mismatches++;
				return;
			end
			exp_out = expected_q.pop_front();
			checked++;
			if (lvl !== exp_out.level) begin
				$error("output_level: expected %0d, got %0d", exp_out.level, lvl);
				mismatches++;
			end
			if (has !== exp_out.has_next) begin
				$error("has_transition: expected %0d, got %0d", exp_out.has_next, has);
				mismatches++;
			end
			if (nxt !== exp_out.next_tick) begin
				$error("next_transition_tick: expected %0d, got %0d",
					exp_out.next_tick, nxt);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic [IN_W-1:0]   s_axis_tdata  = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [0:0]        cfg_index     = '0;
	count_t            cfg_data      = '0;

	pit_output_scoreboard sb = new();

	int unsigned cycle_count  = 0;
	int unsigned settings_cnt = 0;
	bit          quiet        = 1'b0;
	bit          hold_req     = 1'b0;
	bit          hold         = 1'b0;

	pit_channel_output_evaluator_unit #(
		.TICK_BITS(TICK_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// sink: check every result beat, then pick next ready
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
			end
			if (hold) begin
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				stall = quiet ? 0 : gap_len();
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					stall--;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// long receiver hold-off so the row fills and the input stalls
	initial begin
		wait (hold_req);
		hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold = 1'b0;
	end

	task automatic write_reg(reg_index_t idx, count_t data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_query(logic [TICK_BITS-1:0] ticks);
		int gap;
		s_axis_tdata  <= IN_W'(ticks);
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_query(ticks);
		gap = quiet ? 0 : gap_len();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
		end
		repeat (gap) @(posedge clk);
	endtask

	// drop valid and wait for every outstanding result
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic [MODE_BITS-1:0] mode, count_t count);
		drain();
		write_reg(REG_COUNTER_MODE, count_t'(mode));
		write_reg(REG_RELOAD_COUNT, count);
		settings_cnt++;
	endtask

	initial begin
		logic [63:0]          c, d, k, off;
		logic [TICK_BITS-1:0] tmax;
		int                   n_items, r;
		int unsigned          failures;

		tmax = '1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: square wave, full count
		send_query(0);
		send_query(32768);
		send_query(65535);

		set_regs(3'd0, 17'd10);
		send_query(0);
		send_query(9);
		send_query(10);
		send_query(tmax);
		set_regs(3'd1, 17'd0);
		send_query(65535);
		send_query(65536);
		set_regs(3'd2, 17'd1);
		send_query(0);
		send_query(1);
		set_regs(3'd2, FULL_COUNT);
		send_query(65536);
		send_query(65537);
		send_query(tmax);
		set_regs(3'd3, 17'd5);
		send_query(2);
		send_query(3);
		send_query(4);
		set_regs(3'd4, 17'h1ffff);
		send_query(65535);
		send_query(65536);
		send_query(65537);
		set_regs(3'd5, 17'd2);
		send_query(2);
		set_regs(3'd6, 17'd4);
		send_query(8);
		send_query(9);
		set_regs(3'd7, 17'd6);
		send_query(3);
		send_query(tmax);

		for (int p = 0; p < RAND_PHASES; p++) begin
			r = $urandom_range(0, 9);
			if (r < 4) begin
				c = $urandom_range(1, 20);
			end else if (r == 4) begin
				c = 0;
			end else if (r == 5) begin
				c = 64'(FULL_COUNT);
			end else if (r == 6) begin
				c = $urandom_range(65537, 131071);
			end else if (r == 7) begin
				c = $urandom_range(65520, 65535);
			end else begin
				c = $urandom_range(0, 131071);
			end
			set_regs(3'($urandom_range(0, 7)), count_t'(c));
			// query values are chosen around the effective count
			if (c == 0 || c > 64'(FULL_COUNT)) begin
				c = 64'(FULL_COUNT);
			end
			quiet = (p % 5 == 2) || (p == PRESSURE_PH);
			n_items = (p == PRESSURE_PH) ? 200 : 50;
			if (p == PRESSURE_PH) begin
				hold_req = 1'b1;
			end
			for (int i = 0; i < n_items; i++) begin
				r = $urandom_range(0, 5);
				case (r)
					0:       off = 0;
					1:       off = 1;
					2:       off = ((c + 1) >> 1) - 1;
					3:       off = (c + 1) >> 1;
					4:       off = c - 1;
					default: off = $urandom_range(0, 32'(c - 1));
				endcase
				r = $urandom_range(0, 9);
				if (r < 4) begin
					k = $urandom_range(0, 1000);
					d = k * c + off;
				end else if (r == 4) begin
					d = $urandom_range(0, 32'(2 * c + 2));
				end else if (r == 5) begin
					k = 64'($urandom);
					d = k * c + off;
				end else if (r < 8) begin
					d = {$urandom, $urandom};
				end else if (r == 8) begin
					d = c + $urandom_range(0, 2) - 1;
				end else begin
					d = 64'(tmax) - $urandom_range(0, 3);
				end
				send_query(d[TICK_BITS-1:0]);
			end
			quiet = 1'b0;
		end

		// extremes of the count once more at the end
		set_regs(3'd3, 17'd1);
		send_query(tmax);
		set_regs(3'd2, FULL_COUNT);
		send_query(tmax - 1);

		drain();
		repeat (LATENCY + 10) @(posedge clk);

		failures = sb.mismatches + sb.pending();
		$display("Run covered %0d checked queries across %0d register settings,",
			sb.checked, settings_cnt);
		$display("all eight mode codes, edge counts and a %0d-cycle output stall.",
			HOLD_CYCLES);
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
